// ----- hw/rtl/bcpe_pkg.sv -----
package bcpe_pkg;

	localparam int WFRAC = 30;
	localparam int PW    = WFRAC + 1;
	localparam int IDX_W = 3;
	localparam int CNT_W = 4;

	localparam logic [PW-1:0]    ONE_Q30   = PW'(1) << WFRAC;
	localparam logic [CNT_W-1:0] CNT_RESET = CNT_W'(4);

	localparam logic MODE_WRITE = 1'b0;
	localparam logic MODE_EVAL  = 1'b1;

	localparam logic KIND_ACK   = 1'b0;
	localparam logic KIND_POINT = 1'b1;

endpackage

// ----- hw/rtl/bezier_curve_point_eval_unit.sv -----
// channel   signals                                          beat taken when
// -------   -----------------------------------------------  --------------------
// input     start, busy, mode, point_index, coord_x/y/z,     start && !busy
//           t_param
// result    done, result_kind, curve_x/y/z                   done (one cycle)
// config    cfg_we, cfg_wdata (point_count)                  cfg_we
//
// an evaluation builds the powers of t up to t^n and the binomial row of order n (S_POW),
// then runs each point through S_WGT and S_UPD, which share the one 31x31 power multiplier,
// then drains the product pipeline and rounding; n = point count - 1, clamped to 1..MAX_POINTS-1.
// a point write is acknowledged in the next cycle and busy stays low.
// reset clears control state and sets point_count to 4; the point store is not cleared.
// results cannot be stalled: each is a single-cycle done pulse.
module bezier_curve_point_eval_unit import bcpe_pkg::*; #(
	parameter int MAX_POINTS  = 8,
	parameter int COORD_BITS  = 16,
	parameter int T_FRAC_BITS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic                          mode,
	input  logic [IDX_W-1:0]              point_index,
	input  logic signed [COORD_BITS-1:0]  coord_x,
	input  logic signed [COORD_BITS-1:0]  coord_y,
	input  logic signed [COORD_BITS-1:0]  coord_z,
	input  logic [T_FRAC_BITS:0]          t_param,
	output logic                          done,
	output logic                          result_kind,
	output logic signed [COORD_BITS-1:0]  curve_x,
	output logic signed [COORD_BITS-1:0]  curve_y,
	output logic signed [COORD_BITS-1:0]  curve_z,
	input  logic                          cfg_we,
	input  logic [CNT_W-1:0]              cfg_wdata
);

	localparam int AW   = $clog2(MAX_POINTS);
	localparam int BW   = MAX_POINTS - 1;
	localparam int TW   = T_FRAC_BITS + 1;
	localparam int BCW  = BW + 1 + COORD_BITS;
	localparam int PRW  = PW + 1 + BCW;
	localparam int ACW  = PRW;
	localparam int CMPW = CNT_W + AW + 1;
	localparam int WIW  = IDX_W + AW;

	localparam logic [TW-1:0]         TMAX   = {1'b1, {T_FRAC_BITS{1'b0}}};
	localparam logic [2*PW-1:0]       HALF_P = (2*PW)'(1) << (WFRAC - 1);
	localparam logic signed [ACW-1:0] HALF_A = ACW'(1) << (WFRAC - 1);

	typedef enum logic [2:0] {
		S_IDLE,
		S_POW,
		S_WGT,
		S_UPD,
		S_DRAIN
	} state_t;

	state_t state_q;

	logic [CNT_W-1:0] cnt_q;
	logic [AW-1:0]    n_q;
	logic [AW-1:0]    k_q;
	logic [AW-1:0]    i_q;
	logic             v_s1;
	logic             v_s2;
	logic             v_s3;
	logic             fin_q;

	logic [PW-1:0] t30_q;
	logic [PW-1:0] u30_q;
	logic [PW-1:0] up_q;
	logic [PW-1:0] tpow_q [MAX_POINTS];
	logic [BW-1:0] row_q  [MAX_POINTS];

	logic [3*COORD_BITS-1:0] pts_q [MAX_POINTS];
	logic [3*COORD_BITS-1:0] rd_q;

	logic [PW-1:0]           w_s1;
	logic [BW-1:0]           bin_s1;
	logic                    last_s1;
	logic [PW-1:0]           w_s2;
	logic signed [BCW-1:0]   bc_s2 [3];
	logic                    last_s2;
	logic signed [PRW-1:0]   p_s3  [3];
	logic                    last_s3;
	logic signed [ACW-1:0]   acc_q [3];

	logic                    accept;
	logic                    wr_en;
	logic [WIW-1:0]          pidx_w;
	logic [AW-1:0]           wr_addr;
	logic [CMPW-1:0]         cnt_w;
	logic [CMPW-1:0]         cnt_m1;
	logic [AW-1:0]           n_c;
	logic [TW-1:0]           t_c;
	logic [PW-1:0]           t30_c;
	logic [PW-1:0]           u30_c;
	logic [AW-1:0]           tp_addr;
	logic [PW-1:0]           tp_rd;
	logic [PW-1:0]           mul_a;
	logic [PW-1:0]           mul_b;
	logic [2*PW-1:0]         mul_p;
	logic [2*PW-1:0]         mul_rnd;
	logic [PW-1:0]           mul_r;
	logic signed [COORD_BITS-1:0] rd_c [3];
	logic signed [BCW-1:0]   bc_c  [3];
	logic signed [PRW-1:0]   p_c   [3];

	function automatic logic [COORD_BITS-1:0] sat_coord(input logic signed [ACW-1:0] a);
		logic signed [ACW-1:0]      v;
		logic [ACW-COORD_BITS:0]    top;
		logic [COORD_BITS-1:0]      r;
		v   = (a + HALF_A) >>> WFRAC;
		top = v[ACW-1:COORD_BITS-1];
		if ((&top) || !(|top)) begin
			r = v[COORD_BITS-1:0];
		end else if (v[ACW-1]) begin
			r = {1'b1, {(COORD_BITS-1){1'b0}}};
		end else begin
			r = {1'b0, {(COORD_BITS-1){1'b1}}};
		end
		return r;
	endfunction

	assign busy   = (state_q != S_IDLE);
	assign accept = start && !busy;

	// write decode, slots past the store are acknowledged only
	assign pidx_w  = WIW'(point_index);
	assign wr_addr = pidx_w[AW-1:0];
	assign wr_en   = accept && (mode == MODE_WRITE) && (pidx_w < WIW'(MAX_POINTS));

	// point count and t clamping
	assign cnt_w  = CMPW'(cnt_q);
	assign cnt_m1 = cnt_w - CMPW'(1);

	always_comb begin
		if (cnt_w < CMPW'(2)) begin
			n_c = AW'(1);
		end else if (cnt_w > CMPW'(MAX_POINTS)) begin
			n_c = AW'(MAX_POINTS - 1);
		end else begin
			n_c = cnt_m1[AW-1:0];
		end
	end

	assign t_c   = (t_param > TMAX) ? TMAX : t_param;
	assign t30_c = PW'(t_c) << (WFRAC - T_FRAC_BITS);
	assign u30_c = ONE_Q30 - t30_c;

	// shared q1.30 multiplier
	assign tp_addr = (state_q == S_POW) ? AW'(k_q - AW'(1)) : i_q;
	assign tp_rd   = tpow_q[tp_addr];

	always_comb begin
		mul_a = tp_rd;
		mul_b = t30_q;
		case (state_q)
			S_WGT: begin
				mul_b = up_q;
			end
			S_UPD: begin
				mul_a = up_q;
				mul_b = u30_q;
			end
			default: begin
			end
		endcase
	end

	assign mul_p   = (2*PW)'(mul_a) * (2*PW)'(mul_b);
	assign mul_rnd = mul_p + HALF_P;
	assign mul_r   = mul_rnd[WFRAC +: PW];

	assign rd_c[0] = rd_q[3*COORD_BITS-1:2*COORD_BITS];
	assign rd_c[1] = rd_q[2*COORD_BITS-1:COORD_BITS];
	assign rd_c[2] = rd_q[COORD_BITS-1:0];

	for (genvar j = 0; j < 3; j++) begin : g_lane
		assign bc_c[j] = BCW'($signed({1'b0, bin_s1})) * BCW'(rd_c[j]);
		assign p_c[j]  = PRW'($signed({1'b0, w_s2})) * PRW'(bc_s2[j]);
	end

	// point store
	always_ff @(posedge clk) begin
		if (wr_en) begin
			pts_q[wr_addr] <= {coord_x, coord_y, coord_z};
		end
		rd_q <= pts_q[i_q];
	end

	// sequencer and result registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= CNT_RESET;
			n_q         <= '0;
			k_q         <= '0;
			i_q         <= '0;
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			fin_q       <= 1'b0;
			done        <= 1'b0;
			result_kind <= KIND_ACK;
			curve_x     <= '0;
			curve_y     <= '0;
			curve_z     <= '0;
		end else begin
			if (cfg_we) begin
				cnt_q <= cfg_wdata;
			end
			done  <= 1'b0;
			v_s1  <= 1'b0;
			v_s2  <= v_s1;
			v_s3  <= v_s2;
			fin_q <= v_s3 && last_s3;
			if (fin_q) begin
				done        <= 1'b1;
				result_kind <= KIND_POINT;
				curve_x     <= sat_coord(acc_q[0]);
				curve_y     <= sat_coord(acc_q[1]);
				curve_z     <= sat_coord(acc_q[2]);
				state_q     <= S_IDLE;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (mode == MODE_WRITE) begin
							done        <= 1'b1;
							result_kind <= KIND_ACK;
							curve_x     <= '0;
							curve_y     <= '0;
							curve_z     <= '0;
						end else begin
							state_q <= S_POW;
							n_q     <= n_c;
							k_q     <= AW'(1);
						end
					end
				end
				S_POW: begin
					if (k_q == n_q) begin
						state_q <= S_WGT;
						i_q     <= n_q;
					end else begin
						k_q <= k_q + AW'(1);
					end
				end
				S_WGT: begin
					v_s1    <= 1'b1;
					state_q <= S_UPD;
				end
				S_UPD: begin
					if (i_q == '0) begin
						state_q <= S_DRAIN;
					end else begin
						i_q     <= i_q - AW'(1);
						state_q <= S_WGT;
					end
				end
				S_DRAIN: begin
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// powers, binomial row and product pipeline
	always_ff @(posedge clk) begin
		if (accept && (mode == MODE_EVAL)) begin
			t30_q     <= t30_c;
			u30_q     <= u30_c;
			up_q      <= ONE_Q30;
			tpow_q[0] <= ONE_Q30;
			row_q[0]  <= BW'(1);
			for (int j = 1; j < MAX_POINTS; j++) begin
				row_q[j] <= '0;
			end
			for (int j = 0; j < 3; j++) begin
				acc_q[j] <= '0;
			end
		end
		if (state_q == S_POW) begin
			tpow_q[k_q] <= mul_r;
			for (int j = 1; j < MAX_POINTS; j++) begin
				row_q[j] <= row_q[j] + row_q[j-1];
			end
		end
		if (state_q == S_WGT) begin
			w_s1    <= mul_r;
			bin_s1  <= row_q[i_q];
			last_s1 <= (i_q == '0);
		end
		if (state_q == S_UPD) begin
			up_q <= mul_r;
		end
		w_s2    <= w_s1;
		last_s2 <= last_s1;
		last_s3 <= last_s2;
		for (int j = 0; j < 3; j++) begin
			bc_s2[j] <= bc_c[j];
			p_s3[j]  <= p_c[j];
		end
		if (v_s3) begin
			for (int j = 0; j < 3; j++) begin
				acc_q[j] <= acc_q[j] + p_s3[j];
			end
		end
	end

endmodule

// ----- tb/sv/bezier_curve_point_eval_unit_tb.sv -----
`timescale 1ns / 1ps

module bezier_curve_point_eval_unit_tb;
	import bcpe_pkg::*;

	localparam int MAX_POINTS  = 8;
	localparam int COORD_BITS  = 16;
	localparam int T_FRAC_BITS = 16;
	localparam int T_ONE       = 1 << T_FRAC_BITS;
	localparam int SETTLE_CYC  = 32;
	localparam int STALL_LIMIT = 2000;
	localparam int PHASE_BEATS = 68;

	localparam longint unsigned ONE_W  = 64'd1 << WFRAC;
	localparam longint unsigned HALF_W = 64'd1 << (WFRAC - 1);
	localparam longint COORD_MAX = (longint'(1) << (COORD_BITS - 1)) - 1;
	localparam longint COORD_MIN = -(longint'(1) << (COORD_BITS - 1));

	typedef struct {
		logic                         mode;
		logic [IDX_W-1:0]             index;
		logic signed [COORD_BITS-1:0] x;
		logic signed [COORD_BITS-1:0] y;
		logic signed [COORD_BITS-1:0] z;
		logic [T_FRAC_BITS:0]         t;
	} beat_t;

	typedef struct {
		logic                         kind;
		logic signed [COORD_BITS-1:0] x;
		logic signed [COORD_BITS-1:0] y;
		logic signed [COORD_BITS-1:0] z;
	} point_t;

	class curve_scoreboard;
		logic signed [COORD_BITS-1:0] ctrl_pts [MAX_POINTS][3];
		int point_count;
		point_t expected_points [$];
		int errors;

		function new();
			point_count = CNT_RESET;
			errors = 0;
		endfunction

		function void set_count(logic [CNT_W-1:0] v);
			point_count = v;
		endfunction

		function int pending();
			return expected_points.size();
		endfunction

		function longint unsigned qmul(longint unsigned a, longint unsigned b);
			return (a * b + HALF_W) >> WFRAC;
		endfunction

		function longint unsigned choose(int n, int r);
			longint unsigned c = 1;
			for (int k = 1; k <= r; k++)
				c = c * longint'(n - k + 1) / longint'(k);
			return c;
		endfunction

		function logic signed [COORD_BITS-1:0] round_sat(longint acc);
			longint q;
			q = (acc + longint'(HALF_W)) >>> WFRAC;
			if (q > COORD_MAX)
				q = COORD_MAX;
			if (q < COORD_MIN)
				q = COORD_MIN;
			return q[COORD_BITS-1:0];
		endfunction

		function point_t eval_curve(logic [T_FRAC_BITS:0] t_in);
			int cnt;
			int n;
			longint unsigned t_eff;
			longint unsigned t30;
			longint unsigned u30;
			longint unsigned tp;
			longint unsigned up;
			longint unsigned w;
			longint acc [3];
			point_t r;
			cnt = point_count;
			if (cnt < 2)
				cnt = 2;
			if (cnt > MAX_POINTS)
				cnt = MAX_POINTS;
			n = cnt - 1;
			t_eff = (t_in > T_ONE) ? longint'(T_ONE) : longint'(t_in);
			t30 = t_eff << (WFRAC - T_FRAC_BITS);
			u30 = ONE_W - t30;
			acc = '{0, 0, 0};
			for (int i = 0; i <= n; i++) begin
				tp = ONE_W;
				up = ONE_W;
				for (int k = 0; k < i; k++)
					tp = qmul(tp, t30);
				for (int k = 0; k < n - i; k++)
					up = qmul(up, u30);
				w = choose(n, i) * qmul(tp, up);
				for (int j = 0; j < 3; j++)
					acc[j] += longint'(w) * longint'(ctrl_pts[i][j]);
			end
			r.kind = KIND_POINT;
			r.x = round_sat(acc[0]);
			r.y = round_sat(acc[1]);
			r.z = round_sat(acc[2]);
			return r;
		endfunction

		function void note_beat(beat_t b);
			point_t r;
			if (b.mode == MODE_WRITE) begin
				if (b.index < MAX_POINTS) begin
					ctrl_pts[b.index][0] = b.x;
					ctrl_pts[b.index][1] = b.y;
					ctrl_pts[b.index][2] = b.z;
				end
				r = '{KIND_ACK, '0, '0, '0};
			end else begin
				r = eval_curve(b.t);
			end
			expected_points.insert(expected_points.size(), r);
		endfunction

		function void check_point(point_t got);
			point_t exp_pt;
			if (expected_points.size() == 0) begin
				$display("%0t: result with nothing expected, kind %0d", $time, got.kind);
				errors++;
				return;
			end
			exp_pt = expected_points.pop_front();
			if (got.kind !== exp_pt.kind) begin
				$display("%0t: result_kind expected %0d, got %0d", $time, exp_pt.kind, got.kind);
				errors++;
			end
			if (got.x !== exp_pt.x) begin
				$display("%0t: curve_x expected %0d, got %0d", $time, exp_pt.x, got.x);
				errors++;
			end
			if (got.y !== exp_pt.y) begin
				$display("%0t: curve_y expected %0d, got %0d", $time, exp_pt.y, got.y);
				errors++;
			end
			if (got.z !== exp_pt.z) begin
				$display("%0t: curve_z expected %0d, got %0d", $time, exp_pt.z, got.z);
				errors++;
			end
		endfunction
	endclass

	logic                         clk;
	logic                         arst_n;
	logic                         start;
	logic                         busy;
	logic                         mode;
	logic [IDX_W-1:0]             point_index;
	logic signed [COORD_BITS-1:0] coord_x;
	logic signed [COORD_BITS-1:0] coord_y;
	logic signed [COORD_BITS-1:0] coord_z;
	logic [T_FRAC_BITS:0]         t_param;
	logic                         done;
	logic                         result_kind;
	logic signed [COORD_BITS-1:0] curve_x;
	logic signed [COORD_BITS-1:0] curve_y;
	logic signed [COORD_BITS-1:0] curve_z;
	logic                         cfg_we;
	logic [CNT_W-1:0]             cfg_wdata;

	curve_scoreboard sb = new();
	int idle_pct;
	int stall_cyc;

	bezier_curve_point_eval_unit #(
		.MAX_POINTS (MAX_POINTS),
		.COORD_BITS (COORD_BITS),
		.T_FRAC_BITS(T_FRAC_BITS)
	) i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.mode       (mode),
		.point_index(point_index),
		.coord_x    (coord_x),
		.coord_y    (coord_y),
		.coord_z    (coord_z),
		.t_param    (t_param),
		.done       (done),
		.result_kind(result_kind),
		.curve_x    (curve_x),
		.curve_y    (curve_y),
		.curve_z    (curve_z),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// beat and result monitor, stall watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_we)
				sb.set_count(cfg_wdata);
			if (start && !busy)
				sb.note_beat('{mode, point_index, coord_x, coord_y, coord_z, t_param});
			if (done)
				sb.check_point('{result_kind, curve_x, curve_y, curve_z});
			if ((start && !busy) || done)
				stall_cyc <= 0;
			else
				stall_cyc <= stall_cyc + 1;
			if (stall_cyc >= STALL_LIMIT) begin
				$display("*** FAILED ***");
				$finish;
			end
		end
	end

	task automatic send_beat(beat_t b);
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start       <= 1'b1;
		mode        <= b.mode;
		point_index <= b.index;
		coord_x     <= b.x;
		coord_y     <= b.y;
		coord_z     <= b.z;
		t_param     <= b.t;
		do @(posedge clk); while (busy);
	endtask

	task automatic write_point(int idx, logic [15:0] x, logic [15:0] y, logic [15:0] z);
		send_beat('{MODE_WRITE, IDX_W'(idx), x, y, z, (T_FRAC_BITS+1)'($urandom)});
	endtask

	task automatic eval_at(int t);
		send_beat('{MODE_EVAL, IDX_W'($urandom), COORD_BITS'($urandom), COORD_BITS'($urandom),
			COORD_BITS'($urandom), (T_FRAC_BITS+1)'(t)});
	endtask

	// wait for every outstanding result, then let the pipeline go quiet
	task automatic settle();
		start <= 1'b0;
		do @(posedge clk); while (sb.pending() != 0);
		repeat (SETTLE_CYC) @(posedge clk);
	endtask

	task automatic write_count(logic [CNT_W-1:0] v);
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we    <= 1'b0;
	endtask

	function automatic logic [COORD_BITS-1:0] rand_coord();
		case ($urandom_range(7))
			0: return 16'h7FFF;
			1: return 16'h8000;
			2: return 16'h0000;
			default: return COORD_BITS'($urandom);
		endcase
	endfunction

	function automatic logic [T_FRAC_BITS:0] rand_t();
		case ($urandom_range(9))
			0: return '0;
			1: return (T_FRAC_BITS+1)'(T_ONE);
			2: return (T_FRAC_BITS+1)'($urandom_range(2 * T_ONE - 1, T_ONE + 1));
			3: return (T_FRAC_BITS+1)'(1);
			4: return (T_FRAC_BITS+1)'(T_ONE - 1);
			default: return (T_FRAC_BITS+1)'($urandom_range(T_ONE));
		endcase
	endfunction

	task automatic random_beat();
		beat_t b;
		b.mode  = ($urandom_range(99) < 40) ? MODE_WRITE : MODE_EVAL;
		b.index = IDX_W'($urandom);
		b.x     = rand_coord();
		b.y     = rand_coord();
		b.z     = rand_coord();
		b.t     = rand_t();
		send_beat(b);
		if ($urandom_range(49) == 0)
			settle();
	endtask

	initial begin
		logic [CNT_W-1:0] counts [11];
		counts      = '{4'd15, 4'd0, 4'd8, 4'd2, 4'd1, 4'd5, 4'd3, 4'd9, 4'd7, 4'd6, 4'd4};
		arst_n      = 1'b0;
		start       = 1'b0;
		mode        = MODE_WRITE;
		point_index = '0;
		coord_x     = '0;
		coord_y     = '0;
		coord_z     = '0;
		t_param     = '0;
		cfg_we      = 1'b0;
		cfg_wdata   = CNT_RESET;
		stall_cyc   = 0;
		idle_pct    = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// fill every slot before any evaluation, saturating corners first
		for (int i = 0; i < MAX_POINTS; i++)
			write_point(i, 16'h7FFF, 16'h8000, i[0] ? 16'hAAAA : 16'h5555);
		eval_at(0);
		eval_at(T_ONE);
		eval_at(2 * T_ONE - 1);
		eval_at(T_ONE / 2);
		eval_at(1);
		eval_at(T_ONE - 1);
		for (int i = 0; i < 4; i++)
			write_point(i, 16'h8000, 16'h7FFF, i[0] ? 16'hFFFF : 16'h0001);
		eval_at(21845);
		eval_at(43690);

		for (int p = 0; p < 11; p++) begin
			settle();
			write_count(counts[p]);
			idle_pct = (p < 4) ? 24 : (p < 8) ? 72 : 0;
			repeat (PHASE_BEATS) random_beat();
		end
		settle();

		if (sb.errors == 0 && sb.pending() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

// ----- bezier_curve_point_eval_unit.f -----
hw/rtl/bcpe_pkg.sv
hw/rtl/bezier_curve_point_eval_unit.sv
tb/sv/bezier_curve_point_eval_unit_tb.sv
